>>> rtl/chp_pkg.sv
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types and constants of the monotone-chain convex hull block.
// ----------------------------------------------------------------------------
package chp_pkg;

    localparam int IO_BITS = 16;

    typedef logic signed [IO_BITS-1:0] io_word_t;

    typedef struct packed {
        logic valid;
        logic keep;
    } turn_res_t;

endpackage

>>> rtl/chp_ram.sv
// ----------------------------------------------------------------------------
// chp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/chp_cross.sv
// ----------------------------------------------------------------------------
// chp_cross
// Three-stage turn test: cross of (s1 - s0) with (p - s1), keep when > 0.
// ----------------------------------------------------------------------------
module chp_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_BITS-1:0]  s0x,
    input  logic signed [COORD_BITS-1:0]  s0y,
    input  logic signed [COORD_BITS-1:0]  s1x,
    input  logic signed [COORD_BITS-1:0]  s1y,
    input  logic signed [COORD_BITS-1:0]  px,
    input  logic signed [COORD_BITS-1:0]  py,
    output chp_pkg::turn_res_t            res
);
    import chp_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic signed [PW:0]   diff;
    logic                 v1_reg, v2_reg, v3_reg, keep_reg;

    assign diff = {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            keep_reg <= 1'b0;
            ax_reg   <= '0;
            ay_reg   <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            p1_reg   <= '0;
            p2_reg   <= '0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            ax_reg   <= {s1x[COORD_BITS-1], s1x} - {s0x[COORD_BITS-1], s0x};
            ay_reg   <= {s1y[COORD_BITS-1], s1y} - {s0y[COORD_BITS-1], s0y};
            bx_reg   <= {px[COORD_BITS-1], px} - {s1x[COORD_BITS-1], s1x};
            by_reg   <= {py[COORD_BITS-1], py} - {s1y[COORD_BITS-1], s1y};
            p1_reg   <= ax_reg * by_reg;
            p2_reg   <= ay_reg * bx_reg;
            keep_reg <= !diff[PW] && (diff != '0);
        end
    end

    assign res.valid = v3_reg;
    assign res.keep  = keep_reg;

endmodule

>>> rtl/convex_hull_monotone_chain.sv
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain
// Collects points into a sorted memory and emits their convex hull.
// ----------------------------------------------------------------------------
// Points enter one beat at a time and are insertion-sorted by (x, y) in a
// point RAM; each stored entry that sorts after a new point shifts up one
// place. The beat with last_point starts the lower and upper chain passes
// over a stack RAM: each point is read and pushed when the stack is at its
// floor or the turn test in the three-stage cross unit keeps it; each
// failed test pops the stack top. Vertices then leave one beat at a time,
// each read from the stack RAM first, and the output side can stall them.
// A single point gives one beat with hull_empty set. Points beyond
// MAX_POINTS are dropped and overflow is set on every beat of that hull.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chp_pkg::io_word_t point_x,
    input  chp_pkg::io_word_t point_y,
    input  logic              last_point,
    output logic              out_valid,
    input  logic              out_ready,
    output chp_pkg::io_word_t vertex_x,
    output chp_pkg::io_word_t vertex_y,
    output logic              last_vertex,
    output logic              hull_empty,
    output logic              overflow
);
    import chp_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SD  = 2 * MAX_POINTS;
    localparam int SAW = $clog2(SD);
    localparam int TW  = $clog2(SD + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_HLD, S_HP, S_HCHK, S_HWAIT, S_HPOP, S_EMRD, S_EMLD
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [AW-1:0]  i_reg, i_next;
    logic [TW-1:0]  top_reg, top_next;
    logic [TW-1:0]  floor_reg, floor_next;
    logic [SAW-1:0] k_reg, k_next;
    logic           upper_reg, upper_next;
    logic           dropped_reg, dropped_next;
    logic           nlast_reg, nlast_next;
    logic signed [C-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [C-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [C-1:0] r1x_reg, r1x_next, r1y_reg, r1y_next;
    logic signed [C-1:0] r2x_reg, r2x_next, r2y_reg, r2y_next;
    logic           out_valid_reg, out_valid_next;
    io_word_t       vx_reg, vx_next, vy_reg, vy_next;
    logic           lastv_reg, lastv_next, empty_reg, empty_next, ovf_reg, ovf_next;

    logic            pt_we, pt_re, stk_we, stk_re;
    logic [AW-1:0]   pt_waddr, pt_raddr;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [2*C-1:0]  pt_wdata, pt_rdata, stk_wdata, stk_rdata;
    logic signed [C-1:0] pt_rx, pt_ry, stk_rx, stk_ry, px_in, py_in;
    logic [C+IO_BITS-1:0] xin_ext, yin_ext, vx_ext, vy_ext;
    logic            x_start, push, hull_start, load, fin, last_k;
    logic [TW-1:0]   new_top, cnt;
    turn_res_t       xres;

    function automatic logic before_f(
        input logic signed [C-1:0] ax, input logic signed [C-1:0] ay,
        input logic signed [C-1:0] bx, input logic signed [C-1:0] by
    );
        if (ax != bx)
        begin
            return ax < bx;
        end
        return ay < by;
    endfunction

    assign xin_ext = {{C{1'b0}}, point_x};
    assign yin_ext = {{C{1'b0}}, point_y};
    assign px_in   = xin_ext[C-1:0];
    assign py_in   = yin_ext[C-1:0];
    assign pt_rx   = pt_rdata[2*C-1:C];
    assign pt_ry   = pt_rdata[C-1:0];
    assign stk_rx  = stk_rdata[2*C-1:C];
    assign stk_ry  = stk_rdata[C-1:0];
    assign vx_ext  = {{IO_BITS{stk_rx[C-1]}}, stk_rx};
    assign vy_ext  = {{IO_BITS{stk_ry[C-1]}}, stk_ry};
    assign new_top = (top_reg < TW'(SD)) ? top_reg + TW'(1) : top_reg;
    assign cnt     = (top_reg > TW'(MAX_POINTS + 1)) ? TW'(MAX_POINTS) : top_reg - TW'(1);
    assign last_k  = (TW'(k_reg) == cnt - TW'(1));

    chp_ram #(.DEPTH(MAX_POINTS), .WIDTH(2 * C)) u_pt_ram (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
    );

    chp_ram #(.DEPTH(SD), .WIDTH(2 * C)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    chp_cross #(.COORD_BITS(C)) u_cross (
        .clk(clk), .rst_n(rst_n), .start(x_start),
        .s0x(r2x_reg), .s0y(r2y_reg), .s1x(r1x_reg), .s1y(r1y_reg),
        .px(px_reg), .py(py_reg), .res(xres)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        i_next       = i_reg;
        top_next     = top_reg;
        floor_next   = floor_reg;
        k_next       = k_reg;
        upper_next   = upper_reg;
        dropped_next = dropped_reg;
        nlast_next   = nlast_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        r1x_next     = r1x_reg;
        r1y_next     = r1y_reg;
        r2x_next     = r2x_reg;
        r2y_next     = r2y_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        lastv_next   = lastv_reg;
        empty_next   = empty_reg;
        ovf_next     = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pt_we = 1'b0;  pt_waddr = '0;  pt_wdata = '0;
        pt_re = 1'b0;  pt_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
        stk_re = 1'b0; stk_raddr = '0;
        x_start = 1'b0; push = 1'b0; hull_start = 1'b0; load = 1'b0; fin = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    nx_next    = px_in;
                    ny_next    = py_in;
                    nlast_next = last_point;
                    if (count_reg < CW'(MAX_POINTS))
                    begin
                        pos_next = AW'(count_reg);
                        if (count_reg != '0)
                        begin
                            pt_re    = 1'b1;
                            pt_raddr = AW'(count_reg - CW'(1));
                        end
                        state_next = S_INS;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        hull_start   = last_point;
                    end
                end
            end
            S_INS:
            begin
                if (pos_reg != '0 && before_f(nx_reg, ny_reg, pt_rx, pt_ry))
                begin
                    pt_we    = 1'b1;
                    pt_waddr = pos_reg;
                    pt_wdata = pt_rdata;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg > AW'(1))
                    begin
                        pt_re    = 1'b1;
                        pt_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    pt_we      = 1'b1;
                    pt_waddr   = pos_reg;
                    pt_wdata   = {nx_reg, ny_reg};
                    count_next = count_reg + CW'(1);
                    hull_start = nlast_reg;
                    state_next = S_IDLE;
                end
            end
            S_HLD:
            begin
                pt_re      = 1'b1;
                pt_raddr   = i_reg;
                state_next = S_HP;
            end
            S_HP:
            begin
                px_next    = pt_rx;
                py_next    = pt_ry;
                state_next = S_HCHK;
            end
            S_HCHK:
            begin
                if (top_reg > floor_reg)
                begin
                    x_start    = 1'b1;
                    state_next = S_HWAIT;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            S_HWAIT:
            begin
                if (xres.valid)
                begin
                    if (xres.keep)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        top_next = top_reg - TW'(1);
                        r1x_next = r2x_reg;
                        r1y_next = r2y_reg;
                        if (top_reg >= TW'(3))
                        begin
                            stk_re    = 1'b1;
                            stk_raddr = SAW'(top_reg - TW'(3));
                        end
                        state_next = S_HPOP;
                    end
                end
            end
            S_HPOP:
            begin
                r2x_next   = stk_rx;
                r2y_next   = stk_ry;
                state_next = S_HCHK;
            end
            S_EMRD:
            begin
                if (top_reg > TW'(1))
                begin
                    stk_re    = 1'b1;
                    stk_raddr = k_reg;
                end
                state_next = S_EMLD;
            end
            S_EMLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load     = 1'b1;
                    ovf_next = dropped_reg;
                    if (top_reg <= TW'(1))
                    begin
                        vx_next    = '0;
                        vy_next    = '0;
                        lastv_next = 1'b1;
                        empty_next = 1'b1;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        vx_next    = vx_ext[IO_BITS-1:0];
                        vy_next    = vy_ext[IO_BITS-1:0];
                        lastv_next = last_k;
                        empty_next = 1'b0;
                        fin        = last_k;
                        k_next     = k_reg + SAW'(1);
                        state_next = S_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            if (top_reg < TW'(SD))
            begin
                stk_we    = 1'b1;
                stk_waddr = SAW'(top_reg);
                stk_wdata = {px_reg, py_reg};
                r2x_next  = r1x_reg;
                r2y_next  = r1y_reg;
                r1x_next  = px_reg;
                r1y_next  = py_reg;
            end
            top_next   = new_top;
            state_next = S_HLD;
            if (!upper_reg)
            begin
                if (CW'(i_reg) == count_reg - CW'(1))
                begin
                    if (count_reg == CW'(1))
                    begin
                        k_next     = '0;
                        state_next = S_EMRD;
                    end
                    else
                    begin
                        upper_next = 1'b1;
                        floor_next = new_top;
                        i_next     = AW'(count_reg - CW'(2));
                    end
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            else if (i_reg == '0)
            begin
                k_next     = '0;
                state_next = S_EMRD;
            end
            else
            begin
                i_next = i_reg - AW'(1);
            end
        end

        if (hull_start)
        begin
            top_next   = '0;
            i_next     = '0;
            upper_next = 1'b0;
            floor_next = TW'(1);
            state_next = S_HLD;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end

        if (fin)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
            top_next     = '0;
            state_next   = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            i_reg         <= '0;
            top_reg       <= '0;
            floor_reg     <= '0;
            k_reg         <= '0;
            upper_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            nlast_reg     <= 1'b0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            r1x_reg       <= '0;
            r1y_reg       <= '0;
            r2x_reg       <= '0;
            r2y_reg       <= '0;
            out_valid_reg <= 1'b0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            lastv_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            i_reg         <= i_next;
            top_reg       <= top_next;
            floor_reg     <= floor_next;
            k_reg         <= k_next;
            upper_reg     <= upper_next;
            dropped_reg   <= dropped_next;
            nlast_reg     <= nlast_next;
            nx_reg        <= nx_next;
            ny_reg        <= ny_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            r1x_reg       <= r1x_next;
            r1y_reg       <= r1y_next;
            r2x_reg       <= r2x_next;
            r2y_reg       <= r2y_next;
            out_valid_reg <= out_valid_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            lastv_reg     <= lastv_next;
            empty_reg     <= empty_next;
            ovf_reg       <= ovf_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign vertex_x    = vx_reg;
    assign vertex_y    = vy_reg;
    assign last_vertex = lastv_reg;
    assign hull_empty  = empty_reg;
    assign overflow    = ovf_reg;

    a_xres_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        xres.valid |-> state_reg == S_HWAIT)
        else $error("turn result outside wait state");

    a_stk_room: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> top_reg < TW'(SD))
        else $error("stack write beyond depth");

    a_empty_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hull_empty |-> last_vertex && vertex_x == '0 && vertex_y == '0)
        else $error("empty hull beat malformed");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && lastv_next |=> count_reg == '0 && !dropped_reg)
        else $error("set not cleared after final vertex");

endmodule
